// File: hw/rtl/txiq_pkg.sv
`timescale 1ns / 1ps

package txiq_pkg;

   localparam int SENSE_BITS   = 12;
   localparam int TAYLOR_TERMS = 14;
   localparam int RSP_DATA_W   = 40;

   localparam logic [1:0] KIND_SAMPLE  = 2'd0;
   localparam logic [1:0] KIND_READING = 2'd1;
   localparam logic [1:0] KIND_CLEAR   = 2'd2;

   localparam logic [2:0] REG_I_GAIN        = 3'd0;
   localparam logic [2:0] REG_Q_GAIN        = 3'd1;
   localparam logic [2:0] REG_FIXED_GAIN_EN = 3'd2;
   localparam logic [2:0] REG_AMP_PROT_EN   = 3'd3;
   localparam logic [2:0] REG_SUPPLY_MODE   = 3'd4;

   localparam logic [1:0] MODE_3V3 = 2'd0;
   localparam logic [1:0] MODE_5V0 = 2'd1;

   localparam int SENSE_THRESH = 20;

   localparam logic [63:0] LOG2_10_Q32 = 64'd14267572528;
   localparam logic [63:0] DIV_33      = 64'd2730;
   localparam logic [63:0] DIV_50      = 64'd1802;
   localparam logic [31:0] LN2_Q32     = 32'd2977044472;

   localparam logic [31:0] K_33 = 32'((LOG2_10_Q32 + DIV_33 / 2) / DIV_33);
   localparam logic [31:0] K_50 = 32'((LOG2_10_Q32 + DIV_50 / 2) / DIV_50);

   localparam logic [16:0] UNITY_FACTOR = 17'd65536;
   localparam logic signed [17:0] UNITY_GAIN = 18'sd65536;

   localparam int STATE_W     = 17;
   localparam int STATE_DEPTH = 2;

   localparam logic ADDR_FACTOR = 1'b0;
   localparam logic ADDR_WARN   = 1'b1;

endpackage

// File: hw/rtl/txiq_ram.sv
`timescale 1ns / 1ps

module txiq_ram #(
   parameter int WIDTH = txiq_pkg::STATE_W,
   parameter int DEPTH = txiq_pkg::STATE_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/tx_iq_gain_amp_protect_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Contents
// req_      in         req_tvalid/req_tready  tuser: kind; tdata: I, Q, sense reading
// rsp_      out        rsp_tvalid/rsp_tready  tdata: out I, out Q, warning
// csr_      in         csr_wr_en              csr_index selects the register, csr_wr_data
//
// Items are processed one at a time. A reading that trips the protection on a 3.3 V or 5 V
// supply runs the exponential series: 13 multiply and divide rounds on one shared 32x32
// multiplier and a divider that retires 4 quotient bits per cycle.
// The factor and the warning live in a two-entry RAM; reset marks both entries unwritten.
// A finished result waits in the output register, and a new item is taken meanwhile.

module tx_iq_gain_amp_protect_unit #(
   parameter int SENSE_BITS = txiq_pkg::SENSE_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // Fields from bit 0: sample_i[16], sample_q[16], sense_reading[SENSE_BITS].
   input  logic [((32 + SENSE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // Fields from bit 0: kind[2].
   input  logic [1:0]                              req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // Fields from bit 0: out_i[16], out_q[16], warning[1].
   output logic [txiq_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input  logic                                    csr_wr_en,
   input  logic [2:0]                              csr_index,
   input  logic [17:0]                             csr_wr_data
);

   localparam int STATE_AW = $clog2(txiq_pkg::STATE_DEPTH);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RDF  = 4'd1;
   localparam logic [3:0] ST_RDW  = 4'd2;
   localparam logic [3:0] ST_DISP = 4'd3;
   localparam logic [3:0] ST_MUL1 = 4'd4;
   localparam logic [3:0] ST_MUL2 = 4'd5;
   localparam logic [3:0] ST_EXPE = 4'd6;
   localparam logic [3:0] ST_EXPZ = 4'd7;
   localparam logic [3:0] ST_TMUL = 4'd8;
   localparam logic [3:0] ST_TDIV = 4'd9;
   localparam logic [3:0] ST_TACC = 4'd10;
   localparam logic [3:0] ST_FIN  = 4'd11;
   localparam logic [3:0] ST_WRF  = 4'd12;
   localparam logic [3:0] ST_WRW  = 4'd13;
   localparam logic [3:0] ST_OUT  = 4'd14;

   localparam logic [3:0] LAST_TERM = 4'(txiq_pkg::TAYLOR_TERMS);

   logic [3:0] state_ff, state_in;
   logic [1:0] valid_ff, valid_in;

   logic signed [17:0] i_gain_ff, i_gain_in;
   logic signed [17:0] q_gain_ff, q_gain_in;
   logic fixed_en_ff, fixed_en_in;
   logic prot_en_ff, prot_en_in;
   logic [1:0] mode_ff, mode_in;

   logic [1:0] kind_ff, kind_in;
   logic signed [15:0] si_ff, si_in;
   logic signed [15:0] sq_ff, sq_in;
   logic [SENSE_BITS-1:0] sense_ff, sense_in;
   logic [SENSE_BITS-1:0] x_ff, x_in;

   logic [16:0] fac_ff, fac_in;
   logic warn_ff, warn_in;
   logic [16:0] fac_new_ff, fac_new_in;
   logic warn_new_ff, warn_new_in;
   logic out_warn_ff, out_warn_in;

   logic signed [33:0] pi1_ff, pi1_in, pq1_ff, pq1_in;
   logic signed [51:0] pi_ff, pi_in, pq_ff, pq_in;

   logic [4:0] n_ff, n_in;
   logic [31:0] frac_ff, frac_in;
   logic [31:0] z_ff, z_in;
   logic [31:0] term_ff, term_in;
   logic signed [33:0] sum_ff, sum_in;
   logic [3:0] idx_ff, idx_in;
   logic [31:0] div_num_ff, div_num_in;
   logic [3:0] div_rem_ff, div_rem_in;
   logic [2:0] dcnt_ff, dcnt_in;

   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic [txiq_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic accept;
   logic out_free;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_prod;
   logic signed [17:0] gi, gq;
   logic [16:0] fsel;
   logic [31:0] div_num_step;
   logic [3:0] div_rem_step;
   logic [33:0] fin_rnd;
   logic [5:0] fin_sh;
   logic [15:0] out_i_val, out_q_val;

   logic ram_wr_en, ram_rd_en;
   logic [STATE_AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [txiq_pkg::STATE_W-1:0] ram_wr_data, ram_rd_data;

   txiq_ram #(
      .WIDTH(txiq_pkg::STATE_W),
      .DEPTH(txiq_pkg::STATE_DEPTH)
   ) u_state_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   function automatic logic [15:0] round_sat(input logic signed [51:0] p);
      logic neg;
      logic [51:0] mag;
      logic [51:0] rnd;
      logic [19:0] r;
      logic [15:0] q;
      neg = p[51];
      mag = neg ? (52'd0 - $unsigned(p)) : $unsigned(p);
      rnd = mag + (52'd1 << 31);
      r = rnd[51:32];
      if (neg) begin
         q = (r > 20'd32768) ? 16'h8000 : 16'(20'd0 - r);
      end else begin
         q = (r > 20'd32767) ? 16'h7FFF : r[15:0];
      end
      return q;
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_data_ff;

   assign ram_rd_en = accept || (state_ff == ST_RDF);
   assign ram_rd_addr = STATE_AW'((state_ff == ST_RDF) ? txiq_pkg::ADDR_WARN
                                                       : txiq_pkg::ADDR_FACTOR);
   assign ram_wr_en = (state_ff == ST_WRF) || (state_ff == ST_WRW);
   assign ram_wr_addr = STATE_AW'((state_ff == ST_WRW) ? txiq_pkg::ADDR_WARN
                                                       : txiq_pkg::ADDR_FACTOR);
   assign ram_wr_data = (state_ff == ST_WRW) ? {16'd0, warn_new_ff} : fac_new_ff;

   assign gi = fixed_en_ff ? i_gain_ff : txiq_pkg::UNITY_GAIN;
   assign gq = fixed_en_ff ? q_gain_ff : txiq_pkg::UNITY_GAIN;
   assign fsel = prot_en_ff ? fac_ff : txiq_pkg::UNITY_FACTOR;

   always_comb begin
      case (state_ff)
         ST_EXPE: begin
            mul_a = 32'(x_ff);
            mul_b = (mode_ff == txiq_pkg::MODE_3V3) ? txiq_pkg::K_33 : txiq_pkg::K_50;
         end
         ST_EXPZ: begin
            mul_a = frac_ff;
            mul_b = txiq_pkg::LN2_Q32;
         end
         default: begin
            mul_a = term_ff;
            mul_b = z_ff;
         end
      endcase
   end

   assign mul_prod = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      logic [4:0] t;
      logic [3:0] rem;
      logic [31:0] num;
      rem = div_rem_ff;
      num = div_num_ff;
      for (int k = 0; k < 4; k++) begin
         t = {rem, num[31]};
         if (t >= {1'b0, idx_ff}) begin
            rem = 4'(t - {1'b0, idx_ff});
            num = {num[30:0], 1'b1};
         end else begin
            rem = t[3:0];
            num = {num[30:0], 1'b0};
         end
      end
      div_rem_step = rem;
      div_num_step = num;
   end

   assign fin_rnd = $unsigned(sum_ff) + (34'd1 << (5'd15 + n_ff));
   assign fin_sh = 6'(n_ff) + 6'd16;

   assign out_i_val = round_sat(pi_ff);
   assign out_q_val = round_sat(pq_ff);

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      i_gain_in = i_gain_ff;
      q_gain_in = q_gain_ff;
      fixed_en_in = fixed_en_ff;
      prot_en_in = prot_en_ff;
      mode_in = mode_ff;
      kind_in = kind_ff;
      si_in = si_ff;
      sq_in = sq_ff;
      sense_in = sense_ff;
      x_in = x_ff;
      fac_in = fac_ff;
      warn_in = warn_ff;
      fac_new_in = fac_new_ff;
      warn_new_in = warn_new_ff;
      out_warn_in = out_warn_ff;
      pi1_in = pi1_ff;
      pq1_in = pq1_ff;
      pi_in = pi_ff;
      pq_in = pq_ff;
      n_in = n_ff;
      frac_in = frac_ff;
      z_in = z_ff;
      term_in = term_ff;
      sum_in = sum_ff;
      idx_in = idx_ff;
      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      dcnt_in = dcnt_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;

      if (csr_wr_en) begin
         case (csr_index)
            txiq_pkg::REG_I_GAIN:        i_gain_in = $signed(csr_wr_data);
            txiq_pkg::REG_Q_GAIN:        q_gain_in = $signed(csr_wr_data);
            txiq_pkg::REG_FIXED_GAIN_EN: fixed_en_in = csr_wr_data[0];
            txiq_pkg::REG_AMP_PROT_EN:   prot_en_in = csr_wr_data[0];
            txiq_pkg::REG_SUPPLY_MODE:   mode_in = csr_wr_data[1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_tuser;
               si_in = $signed(req_tdata[15:0]);
               sq_in = $signed(req_tdata[31:16]);
               sense_in = req_tdata[32 +: SENSE_BITS];
               state_in = ST_RDF;
            end
         end
         ST_RDF: begin
            fac_in = valid_ff[txiq_pkg::ADDR_FACTOR] ? ram_rd_data : txiq_pkg::UNITY_FACTOR;
            state_in = ST_RDW;
         end
         ST_RDW: begin
            warn_in = valid_ff[txiq_pkg::ADDR_WARN] ? ram_rd_data[0] : 1'b0;
            state_in = ST_DISP;
         end
         ST_DISP: begin
            out_warn_in = warn_ff;
            warn_new_in = warn_ff;
            fac_new_in = fac_ff;
            x_in = sense_ff - SENSE_BITS'(txiq_pkg::SENSE_THRESH);
            case (kind_ff)
               txiq_pkg::KIND_SAMPLE: begin
                  state_in = ST_MUL1;
               end
               txiq_pkg::KIND_READING: begin
                  if (prot_en_ff && (sense_ff >= SENSE_BITS'(txiq_pkg::SENSE_THRESH))) begin
                     warn_new_in = 1'b1;
                     out_warn_in = 1'b1;
                     if ((mode_ff == txiq_pkg::MODE_3V3) || (mode_ff == txiq_pkg::MODE_5V0)) begin
                        state_in = ST_EXPE;
                     end else begin
                        fac_new_in = 17'd0;
                        state_in = ST_WRF;
                     end
                  end else begin
                     fac_new_in = txiq_pkg::UNITY_FACTOR;
                     state_in = ST_WRF;
                  end
               end
               txiq_pkg::KIND_CLEAR: begin
                  warn_new_in = 1'b0;
                  state_in = ST_WRW;
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_MUL1: begin
            pi1_in = si_ff * gi;
            pq1_in = sq_ff * gq;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            pi_in = pi1_ff * $signed({1'b0, fsel});
            pq_in = pq1_ff * $signed({1'b0, fsel});
            state_in = ST_OUT;
         end
         ST_EXPE: begin
            if (mul_prod[63:32] >= 32'd17) begin
               fac_new_in = 17'd0;
               state_in = ST_WRF;
            end else begin
               n_in = mul_prod[36:32];
               frac_in = mul_prod[31:0];
               state_in = ST_EXPZ;
            end
         end
         ST_EXPZ: begin
            z_in = mul_prod[63:32];
            term_in = mul_prod[63:32];
            sum_in = $signed(34'd1 << 32) - $signed({2'b00, mul_prod[63:32]});
            idx_in = 4'd2;
            state_in = ST_TMUL;
         end
         ST_TMUL: begin
            div_num_in = mul_prod[63:32];
            div_rem_in = 4'd0;
            dcnt_in = 3'd0;
            state_in = ST_TDIV;
         end
         ST_TDIV: begin
            div_num_in = div_num_step;
            div_rem_in = div_rem_step;
            dcnt_in = dcnt_ff + 3'd1;
            if (dcnt_ff == 3'd7) begin
               state_in = ST_TACC;
            end
         end
         ST_TACC: begin
            term_in = div_num_ff;
            if (idx_ff[0]) begin
               sum_in = sum_ff - $signed({2'b00, div_num_ff});
            end else begin
               sum_in = sum_ff + $signed({2'b00, div_num_ff});
            end
            idx_in = idx_ff + 4'd1;
            state_in = (idx_ff == LAST_TERM) ? ST_FIN : ST_TMUL;
         end
         ST_FIN: begin
            fac_new_in = 17'(fin_rnd >> fin_sh);
            state_in = ST_WRF;
         end
         ST_WRF: begin
            valid_in[txiq_pkg::ADDR_FACTOR] = 1'b1;
            state_in = ST_WRW;
         end
         ST_WRW: begin
            valid_in[txiq_pkg::ADDR_WARN] = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               if (kind_ff == txiq_pkg::KIND_SAMPLE) begin
                  rsp_data_in = {7'd0, out_warn_ff, out_q_val, out_i_val};
               end else begin
                  rsp_data_in = {7'd0, out_warn_ff, 32'd0};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 2'b00;
         i_gain_ff <= txiq_pkg::UNITY_GAIN;
         q_gain_ff <= txiq_pkg::UNITY_GAIN;
         fixed_en_ff <= 1'b0;
         prot_en_ff <= 1'b0;
         mode_ff <= txiq_pkg::MODE_3V3;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         i_gain_ff <= i_gain_in;
         q_gain_ff <= q_gain_in;
         fixed_en_ff <= fixed_en_in;
         prot_en_ff <= prot_en_in;
         mode_ff <= mode_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      si_ff <= si_in;
      sq_ff <= sq_in;
      sense_ff <= sense_in;
      x_ff <= x_in;
      fac_ff <= fac_in;
      warn_ff <= warn_in;
      fac_new_ff <= fac_new_in;
      warn_new_ff <= warn_new_in;
      out_warn_ff <= out_warn_in;
      pi1_ff <= pi1_in;
      pq1_ff <= pq1_in;
      pi_ff <= pi_in;
      pq_ff <= pq_in;
      n_ff <= n_in;
      frac_ff <= frac_in;
      z_ff <= z_in;
      term_ff <= term_in;
      sum_ff <= sum_in;
      idx_ff <= idx_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      dcnt_ff <= dcnt_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
